// File: src/i64dec_pkg.sv
// Package for the 64-bit integer to decimal ASCII converter.
// Holds field widths, character codes and the sequencer state type.
// No dependencies.
`default_nettype none

package i64dec_pkg;

  // Default conversion width of the value field.
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Fixed field widths.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned DIGIT_W = 4;

  // Character codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Longest text the result channel can carry.
  localparam logic [LEN_W-1:0] MAX_TEXT_LEN = 5'd20;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage : i64dec_pkg

`default_nettype wire

// File: src/int64_to_decimal_ascii.sv
// Integer to decimal ASCII converter: top level and only module.
// Depends on i64dec_pkg for widths, character codes and the state type.
// Uses a shared shift-and-add-3 (double dabble) unit, one bit per cycle.

// A value transaction is taken only while the block is idle. The magnitude is
// converted to BCD one bit per cycle by a single shift-and-add-3 unit. Leading
// zero digits are then stripped one per cycle, up to DIGITS-1 of them (19 at
// the default width), and the first character is loaded, after which one
// character per cycle is offered on the result stream while the stream is ready,
// sign first. Stripped and printed digits together always make DIGITS. Every
// character carries the full text length, and the final one is marked with tlast.
`default_nettype none

module int64_to_decimal_ascii #(
  parameter int unsigned DATA_WIDTH = i64dec_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input stream.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [i64dec_pkg::VALUE_W-1:0] in_tdata,  // [63:0] value
  input  wire logic                           in_tuser,  // [0] is_signed
  // Result stream.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [i64dec_pkg::CHAR_W-1:0]       out_tdata, // [7:0] character
  output logic                                out_tlast, // is_last
  output logic [i64dec_pkg::LEN_W-1:0]        out_tuser  // [4:0] text_length
);

  // Number of decimal digits of 2^DATA_WIDTH - 1.
  localparam int unsigned DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W  = DIGITS * i64dec_pkg::DIGIT_W;
  localparam int unsigned CNT_W  = $clog2(DATA_WIDTH);
  localparam int unsigned DW     = i64dec_pkg::DIGIT_W;
  localparam int unsigned LW     = i64dec_pkg::LEN_W;
  localparam int unsigned CW     = i64dec_pkg::CHAR_W;

  i64dec_pkg::state_t    state_r, state_nxt;
  logic [DATA_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LW-1:0]         nd_r, nd_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [LW-1:0]         rem_r, rem_nxt;
  logic                  neg_r, neg_nxt;
  logic [CW-1:0]         char_r, char_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [DATA_WIDTH-1:0] in_val;
  logic                  in_neg;
  logic [BCD_W-1:0]      bcd_adj;
  logic [DW-1:0]         top_digit;
  logic [CW-1:0]         top_char;

  // Port outputs.
  assign in_tready  = (state_r == i64dec_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = (rem_r == LW'(1));
  assign out_tuser  = len_r;

  // Sign and raw value of the incoming transaction.
  assign in_val = in_tdata[DATA_WIDTH-1:0];
  assign in_neg = in_tuser & in_val[DATA_WIDTH-1];

  // Most significant BCD digit and its character.
  assign top_digit = bcd_r[BCD_W-1 -: DW];
  assign top_char  = i64dec_pkg::ASCII_ZERO | {{(CW-DW){1'b0}}, top_digit};

  // Shared add-3 correction across all digits before each shift.
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < int'(DIGITS); i++) begin
      if (bcd_r[i*DW +: DW] >= DW'(5)) begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW] + DW'(3);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    nd_nxt        = nd_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    char_nxt      = char_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      i64dec_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mag_nxt   = in_neg ? (DATA_WIDTH'(0) - in_val) : in_val;
          neg_nxt   = in_neg;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
          nd_nxt    = LW'(DIGITS);
          state_nxt = i64dec_pkg::ST_CONV;
        end
      end
      i64dec_pkg::ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[DATA_WIDTH-1]};
        mag_nxt = {mag_r[DATA_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = i64dec_pkg::ST_NORM;
        end
      end
      i64dec_pkg::ST_NORM: begin
        if ((top_digit == '0) && (nd_r > LW'(1))) begin
          bcd_nxt = {bcd_r[BCD_W-DW-1:0], {DW{1'b0}}};
          nd_nxt  = nd_r - LW'(1);
        end else begin
          len_nxt       = nd_r + LW'(neg_r);
          rem_nxt       = nd_r + LW'(neg_r);
          out_valid_nxt = 1'b1;
          state_nxt     = i64dec_pkg::ST_EMIT;
          if (neg_r) begin
            char_nxt = i64dec_pkg::ASCII_MINUS;
            neg_nxt  = 1'b0;
          end else begin
            char_nxt = top_char;
            bcd_nxt  = {bcd_r[BCD_W-DW-1:0], {DW{1'b0}}};
          end
        end
      end
      i64dec_pkg::ST_EMIT: begin
        if (out_tready) begin
          if (rem_r == LW'(1)) begin
            out_valid_nxt = 1'b0;
            state_nxt     = i64dec_pkg::ST_IDLE;
          end else begin
            rem_nxt  = rem_r - LW'(1);
            char_nxt = top_char;
            bcd_nxt  = {bcd_r[BCD_W-DW-1:0], {DW{1'b0}}};
          end
        end
      end
      default: begin
        state_nxt     = i64dec_pkg::ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i64dec_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    nd_r   <= nd_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
  end

  // The block never offers a result while it is ready for a new value.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("result offered while idle");

  // A taken value keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("block ready straight after taking a value");

  // Delivering the final character returns the block to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not idle after final character");

  // The sign only ever comes as the first character of a text.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata == i64dec_pkg::ASCII_MINUS)) |->
      ((rem_r == out_tuser) && !out_tlast))
    else $error("sign not in first place");

  // The reported length stays within the text limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser != '0) && (out_tuser <= i64dec_pkg::MAX_TEXT_LEN)
                    && (rem_r <= out_tuser)))
    else $error("text length out of range");

endmodule : int64_to_decimal_ascii

`default_nettype wire
